### rtl/so3_exponential_map_core_macros.svh
// assertion helpers for the exponential map core
// each use is one labeled concurrent assertion on the rising edge of clk
`ifndef SO3_EXPONENTIAL_MAP_CORE_MACROS_SVH
`define SO3_EXPONENTIAL_MAP_CORE_MACROS_SVH
// checked outside reset only
`define SO3_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define SO3_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/so3em_pkg.sv
// ----------------------------------------------------------------------------
// so3em_pkg
// Types, constants and tables shared by the SO(3) exponential map pipeline.
// ----------------------------------------------------------------------------
package so3em_pkg;

  localparam int SQ_STEPS     = 32;
  localparam int QUO_STEPS    = 4;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_STEPS    = 53;

  localparam logic [63:0] T_TINY   = 64'd720575941;
  localparam logic [63:0] T_SMALL  = 64'd72057594038;
  localparam logic [27:0] C6_Q30   = 28'd178956976;
  localparam logic [25:0] C24_Q30  = 26'd44739244;
  localparam logic [30:0] HALF_PI  = 31'd1686629713;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [31:0] Q30_ONE  = 32'd1073741824;
  localparam logic [31:0] Q30_HALF = 32'd536870912;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } rot_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } mat_t;

  // vector, squared norm and the series coefficients for short vectors
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        t;
    logic               big;
    logic [31:0]        ka_s;
    logic [31:0]        kb_s;
  } side_t;

  typedef struct packed {
    logic [31:0] th;
    logic [30:0] ang;
    quad_t       quad;
  } ang_t;

  typedef struct packed {
    logic [31:0]        th;
    quad_t              quad;
    logic signed [33:0] c;
    logic signed [33:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        ka_mag;
    logic               ka_neg;
    logic [31:0]        kb;
  } coef_t;

  // arctangent of 2^-i in Q30
  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/so3_exponential_map_core.sv
// ----------------------------------------------------------------------------
// so3_exponential_map_core
// Rotation vector (Q3.28) to rotation matrix (Q1.30) by the Rodrigues
// formula, sin and cos from a pipelined CORDIC.
// ----------------------------------------------------------------------------
//   channel  payload  width  role
//   rot      rot_t    96     request: rotation vector x, y, z
//   mat      mat_t    288    result: row-major 3x3 matrix
//
// One request per cycle while mat is not stalled; stages in order: front,
// square root and quadrant, CORDIC, dividers, matrix.
// The two 53-step restoring dividers set the depth.
// Reset clears every stage valid; data registers are not reset.
// A stall on mat freezes all stages together; rot_ready drops while reset is
// high and while a result sits in the output register and is not taken.
// ----------------------------------------------------------------------------
module so3_exponential_map_core import so3em_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rot_valid,
  output logic rot_ready,
  input  rot_t rot,
  output logic mat_valid,
  input  logic mat_ready,
  output mat_t mat
);

  logic  en;
  logic  f_valid, s_valid, c_valid, k_valid;
  side_t f_side, s_side, c_side;
  ang_t  s_ang;
  trig_t c_trig;
  coef_t k_coef;

  assign en        = !mat_valid || mat_ready;
  // no request is taken while the stage valids are being cleared
  assign rot_ready = en && !rst;

  so3em_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .rot       (rot),
    .out_valid (f_valid),
    .side      (f_side)
  );

  so3em_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_ang   (s_ang)
  );

  so3em_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_side   (s_side),
    .in_ang    (s_ang),
    .out_valid (c_valid),
    .out_side  (c_side),
    .out_trig  (c_trig)
  );

  so3em_kdiv u_kdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_side   (c_side),
    .in_trig   (c_trig),
    .out_valid (k_valid),
    .out_coef  (k_coef)
  );

  so3em_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (k_valid),
    .coef      (k_coef),
    .out_valid (mat_valid),
    .mat       (mat)
  );

endmodule

### rtl/so3em_front.sv
// ----------------------------------------------------------------------------
// so3em_front
// Squared norm of the rotation vector and the series coefficients used
// when the angle is very small. Four register stages.
// ----------------------------------------------------------------------------
module so3em_front import so3em_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  rot_t  rot,
  output logic  out_valid,
  output side_t side
);

  logic               vld1, vld2, vld3;
  logic signed [31:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic signed [63:0] xx_p, yy_p, zz_p;
  logic [63:0]        xx1, yy1, zz1, t2, t3;
  logic [64:0]        p6;
  logic [62:0]        p24;
  logic [65:0]        p6r;
  logic [63:0]        p24r;
  logic               tiny3, small3;
  logic [9:0]         ct3;
  logic [7:0]         c24r3;
  logic [30:0]        omct;
  logic [40:0]        pk;
  logic [41:0]        pkr;
  logic [31:0]        ka_tiny, ka_small, kb_small;

  assign xx_p = rot.rot_x * rot.rot_x;
  assign yy_p = rot.rot_y * rot.rot_y;
  assign zz_p = rot.rot_z * rot.rot_z;

  // short vectors only: t fits 37 bits there
  assign p6   = C6_Q30 * t2[36:0];
  assign p24  = C24_Q30 * t2[36:0];
  assign p6r  = {1'b0, p6} + (66'd1 << 55);
  assign p24r = {1'b0, p24} + (64'd1 << 55);

  assign omct     = Q30_ONE[30:0] - {21'd0, ct3};
  assign pk       = {31'd0, ct3} * {10'd0, omct};
  assign pkr      = {1'b0, pk} + (42'd1 << 29);
  assign ka_tiny  = Q30_ONE - {22'd0, ct3};
  assign ka_small = Q30_ONE - {20'd0, pkr[41:30]};
  assign kb_small = Q30_HALF - {24'd0, c24r3};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      out_valid <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= rot.rot_x;
      y1     <= rot.rot_y;
      z1     <= rot.rot_z;
      xx1    <= xx_p;
      yy1    <= yy_p;
      zz1    <= zz_p;
      x2     <= x1;
      y2     <= y1;
      z2     <= z1;
      t2     <= xx1 + yy1 + zz1;
      x3     <= x2;
      y3     <= y2;
      z3     <= z2;
      t3     <= t2;
      tiny3  <= t2 < T_TINY;
      small3 <= t2 < T_SMALL;
      ct3    <= p6r[65:56];
      c24r3  <= p24r[63:56];
      side.x <= x3;
      side.y <= y3;
      side.z <= z3;
      side.t <= t3;
      side.big <= !small3;
      if (tiny3) begin
        side.ka_s <= ka_tiny;
        side.kb_s <= Q30_HALF;
      end else begin
        side.ka_s <= ka_small;
        side.kb_s <= kb_small;
      end
    end
  end

endmodule

### rtl/so3em_sqrt.sv
// ----------------------------------------------------------------------------
// so3em_sqrt
// Integer square root of the squared norm, one result bit per stage, then
// reduction of the angle by quarter turns, one quotient bit per stage.
// ----------------------------------------------------------------------------
module so3em_sqrt import so3em_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  output logic  out_valid,
  output side_t out_side,
  output ang_t  out_ang
);

  logic        svld  [SQ_STEPS+1];
  side_t       sside [SQ_STEPS+1];
  logic [63:0] srem  [SQ_STEPS+1];
  logic [63:0] sres  [SQ_STEPS+1];

  logic        qvld  [QUO_STEPS+1];
  side_t       qside [QUO_STEPS+1];
  logic [31:0] qth   [QUO_STEPS+1];
  logic [33:0] qrem  [QUO_STEPS+1];
  logic [3:0]  qq    [QUO_STEPS+1];

  assign svld[0]  = in_valid;
  assign sside[0] = in_side;
  assign srem[0]  = in_side.t;
  assign sres[0]  = '0;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = sres[i] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        svld[i+1] <= 1'b0;
      end else if (en) begin
        svld[i+1] <= svld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sside[i+1] <= sside[i];
        if (srem[i] >= trial) begin
          srem[i+1] <= srem[i] - trial;
          sres[i+1] <= (sres[i] >> 1) + BIT;
        end else begin
          srem[i+1] <= srem[i];
          sres[i+1] <= sres[i] >> 1;
        end
      end
    end
  end

  // angle in Q30 is the Q28 root shifted by two
  assign qvld[0]  = svld[SQ_STEPS];
  assign qside[0] = sside[SQ_STEPS];
  assign qth[0]   = sres[SQ_STEPS][31:0];
  assign qrem[0]  = {sres[SQ_STEPS][31:0], 2'b00};
  assign qq[0]    = '0;

  for (genvar j = 0; j < QUO_STEPS; j++) begin : g_quo
    localparam int          K    = QUO_STEPS - 1 - j;
    localparam logic [33:0] STEP = {3'b000, HALF_PI} << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        qvld[j+1] <= 1'b0;
      end else if (en) begin
        qvld[j+1] <= qvld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qside[j+1] <= qside[j];
        qth[j+1]   <= qth[j];
        if (qrem[j] >= STEP) begin
          qrem[j+1] <= qrem[j] - STEP;
          qq[j+1]   <= qq[j] | (4'd1 << K);
        end else begin
          qrem[j+1] <= qrem[j];
          qq[j+1]   <= qq[j];
        end
      end
    end
  end

  assign out_valid    = qvld[QUO_STEPS];
  assign out_side     = qside[QUO_STEPS];
  assign out_ang.th   = qth[QUO_STEPS];
  assign out_ang.ang  = qrem[QUO_STEPS][30:0];
  assign out_ang.quad = quad_t'(qq[QUO_STEPS][1:0]);

endmodule

### rtl/so3em_cordic.sv
// ----------------------------------------------------------------------------
// so3em_cordic
// Rotation-mode CORDIC, one micro-rotation per stage, giving cosine and
// sine in Q30 of the reduced angle.
// ----------------------------------------------------------------------------
module so3em_cordic import so3em_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  input  ang_t  in_ang,
  output logic  out_valid,
  output side_t out_side,
  output trig_t out_trig
);

  logic               cvld  [CORDIC_STEPS+1];
  side_t              cside [CORDIC_STEPS+1];
  logic [31:0]        cth   [CORDIC_STEPS+1];
  quad_t              cquad [CORDIC_STEPS+1];
  logic signed [33:0] cx    [CORDIC_STEPS+1];
  logic signed [33:0] cy    [CORDIC_STEPS+1];
  logic signed [32:0] cz    [CORDIC_STEPS+1];

  assign cvld[0]  = in_valid;
  assign cside[0] = in_side;
  assign cth[0]   = in_ang.th;
  assign cquad[0] = in_ang.quad;
  assign cx[0]    = $signed(CORDIC_GAIN);
  assign cy[0]    = '0;
  assign cz[0]    = $signed({2'b00, in_ang.ang});

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [32:0] ATAN = $signed({3'b000, atan_q30(i)});
    logic signed [33:0] xs, ys;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cvld[i+1] <= 1'b0;
      end else if (en) begin
        cvld[i+1] <= cvld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cside[i+1] <= cside[i];
        cth[i+1]   <= cth[i];
        cquad[i+1] <= cquad[i];
        if (!cz[i][32]) begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ATAN;
        end else begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ATAN;
        end
      end
    end
  end

  assign out_valid     = cvld[CORDIC_STEPS];
  assign out_side      = cside[CORDIC_STEPS];
  assign out_trig.th   = cth[CORDIC_STEPS];
  assign out_trig.quad = cquad[CORDIC_STEPS];
  assign out_trig.c    = cx[CORDIC_STEPS];
  assign out_trig.s    = cy[CORDIC_STEPS];

endmodule

### rtl/so3em_kdiv.sv
// ----------------------------------------------------------------------------
// so3em_kdiv
// Quadrant unfolding, then two restoring dividers in lockstep, one quotient
// bit per stage: kA = sin/theta and kB = (1 - cos)/theta^2, both Q30 and
// rounded half up. Picks the series coefficients for short vectors.
// ----------------------------------------------------------------------------
module so3em_kdiv import so3em_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  side_t in_side,
  input  trig_t in_trig,
  output logic  out_valid,
  output coef_t out_coef
);

  localparam int LANES = 2;

  logic signed [34:0] ce, se, sn, cs;
  logic [34:0]        sn_mag;
  logic signed [35:0] omc_full;
  logic [31:0]        omc;

  logic                 dvld  [DIV_STEPS+1];
  side_t                dside [DIV_STEPS+1];
  logic                 dneg  [DIV_STEPS+1];
  logic [63:0]          dr    [LANES][DIV_STEPS+1];
  logic [63:0]          dd    [LANES][DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dn    [LANES][DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dq    [LANES][DIV_STEPS+1];

  logic [31:0] kq [LANES];

  assign ce = 35'(in_trig.c);
  assign se = 35'(in_trig.s);

  always_comb begin
    unique case (in_trig.quad)
      QUAD_0: begin sn = se;  cs = ce;  end
      QUAD_1: begin sn = ce;  cs = -se; end
      QUAD_2: begin sn = -se; cs = -ce; end
      QUAD_3: begin sn = -ce; cs = se;  end
      default: begin sn = se; cs = ce;  end
    endcase
  end

  assign sn_mag   = sn[34] ? 35'(-sn) : 35'(sn);
  assign omc_full = $signed({4'd0, Q30_ONE}) - 36'(cs);
  // cosine slightly above one from rounding: clamp so kB stays nonnegative
  assign omc      = omc_full[35] ? '0 : omc_full[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= in_valid;
    end
  end

  // numerator bits above the quotient width go straight into the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= in_side;
      dneg[0]  <= sn[34];
      dr[0][0] <= 64'(sn_mag >> 25);
      dd[0][0] <= {32'd0, in_trig.th};
      dn[0][0] <= {sn_mag[24:0], 28'd0};
      dq[0][0] <= '0;
      dr[1][0] <= {29'd0, omc, 3'b000};
      dd[1][0] <= in_side.t;
      dn[1][0] <= '0;
      dq[1][0] <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (en) begin
        dvld[k+1] <= dvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[k+1] <= dside[k];
        dneg[k+1]  <= dneg[k];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [64:0] r2, dif;
      assign r2  = {dr[l][k], dn[l][k][DIV_STEPS-1]};
      assign dif = r2 - {1'b0, dd[l][k]};

      always_ff @(posedge clk) begin
        if (en) begin
          dd[l][k+1] <= dd[l][k];
          dn[l][k+1] <= {dn[l][k][DIV_STEPS-2:0], 1'b0};
          if (r2 >= {1'b0, dd[l][k]}) begin
            dr[l][k+1] <= dif[63:0];
            dq[l][k+1] <= {dq[l][k][DIV_STEPS-2:0], 1'b1};
          end else begin
            dr[l][k+1] <= r2[63:0];
            dq[l][k+1] <= {dq[l][k][DIV_STEPS-2:0], 1'b0};
          end
        end
      end
    end

    // round half up, then clip to the coefficient width
    logic              up;
    logic [DIV_STEPS:0] qr;
    assign up    = {dr[l][DIV_STEPS], 1'b0} >= {1'b0, dd[l][DIV_STEPS]};
    assign qr    = {1'b0, dq[l][DIV_STEPS]} + (DIV_STEPS+1)'(up);
    assign kq[l] = (qr[DIV_STEPS:32] != '0) ? '1 : qr[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_coef.x <= dside[DIV_STEPS].x;
      out_coef.y <= dside[DIV_STEPS].y;
      out_coef.z <= dside[DIV_STEPS].z;
      if (dside[DIV_STEPS].big) begin
        out_coef.ka_mag <= kq[0];
        out_coef.ka_neg <= dneg[DIV_STEPS];
        out_coef.kb     <= kq[1];
      end else begin
        out_coef.ka_mag <= dside[DIV_STEPS].ka_s;
        out_coef.ka_neg <= 1'b0;
        out_coef.kb     <= dside[DIV_STEPS].kb_s;
      end
    end
  end

endmodule

### rtl/so3em_back.sv
// ----------------------------------------------------------------------------
// so3em_back
// Rodrigues matrix from kA and kB: vector products, wide products cut into
// two 32-bit halves, rounding to Q30 and saturation. Four register stages,
// the last one being the output register.
// ----------------------------------------------------------------------------
module so3em_back import so3em_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  coef_t coef,
  output logic  out_valid,
  output mat_t  mat
);

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -43'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic vld1, vld2, vld3;

  // stage 1: magnitudes and vector products
  logic [31:0] ax, ay, az;
  logic [63:0] sq1 [3];
  logic [63:0] cr1 [3];
  logic        crn1 [3];
  logic [31:0] am1 [3];
  logic        amn1 [3];
  logic [31:0] ka1, kb1;
  logic        kan1;

  // stage 2: partial products
  logic [63:0] dsum [3];
  logic [63:0] dlo2 [3];
  logic [63:0] dhi2 [3];
  logic [63:0] blo2 [3];
  logic [63:0] bhi2 [3];
  logic        bn2 [3];
  logic [63:0] ap2 [3];
  logic        an2 [3];

  // stage 3: rounded signed terms
  logic signed [40:0] dm3 [3];
  logic signed [40:0] bm3 [3];
  logic signed [37:0] am3 [3];

  assign ax = coef.x[31] ? 32'(-coef.x) : 32'(coef.x);
  assign ay = coef.y[31] ? 32'(-coef.y) : 32'(coef.y);
  assign az = coef.z[31] ? 32'(-coef.z) : 32'(coef.z);

  assign dsum[0] = sq1[1] + sq1[2];
  assign dsum[1] = sq1[0] + sq1[2];
  assign dsum[2] = sq1[0] + sq1[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      vld3      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      vld3      <= vld2;
      out_valid <= vld3;
    end
  end

  // cross products pair with the component that does not appear in them:
  // xy with z, xz with y, yz with x
  always_ff @(posedge clk) begin
    if (en) begin
      sq1[0]  <= {32'd0, ax} * {32'd0, ax};
      sq1[1]  <= {32'd0, ay} * {32'd0, ay};
      sq1[2]  <= {32'd0, az} * {32'd0, az};
      cr1[0]  <= {32'd0, ax} * {32'd0, ay};
      cr1[1]  <= {32'd0, ax} * {32'd0, az};
      cr1[2]  <= {32'd0, ay} * {32'd0, az};
      crn1[0] <= coef.x[31] ^ coef.y[31];
      crn1[1] <= coef.x[31] ^ coef.z[31];
      crn1[2] <= coef.y[31] ^ coef.z[31];
      am1[0]  <= az;
      am1[1]  <= ay;
      am1[2]  <= ax;
      amn1[0] <= coef.z[31];
      amn1[1] <= coef.y[31];
      amn1[2] <= coef.x[31];
      ka1     <= coef.ka_mag;
      kan1    <= coef.ka_neg;
      kb1     <= coef.kb;
    end
  end

  for (genvar n = 0; n < 3; n++) begin : g_term
    logic [95:0] dp, bp;
    logic [95:0] dpr, bpr;
    logic [64:0] apr;

    always_ff @(posedge clk) begin
      if (en) begin
        dlo2[n] <= {32'd0, kb1} * {32'd0, dsum[n][31:0]};
        dhi2[n] <= {32'd0, kb1} * {32'd0, dsum[n][63:32]};
        blo2[n] <= {32'd0, kb1} * {32'd0, cr1[n][31:0]};
        bhi2[n] <= {32'd0, kb1} * {32'd0, cr1[n][63:32]};
        bn2[n]  <= crn1[n];
        ap2[n]  <= {32'd0, ka1} * {32'd0, am1[n]};
        an2[n]  <= kan1 ^ amn1[n];
      end
    end

    assign dp  = {32'd0, dlo2[n]} + {dhi2[n], 32'd0};
    assign bp  = {32'd0, blo2[n]} + {bhi2[n], 32'd0};
    assign dpr = dp + (96'd1 << 55);
    assign bpr = bp + (96'd1 << 55);
    assign apr = {1'b0, ap2[n]} + (65'd1 << 27);

    always_ff @(posedge clk) begin
      if (en) begin
        dm3[n] <= $signed({1'b0, dpr[95:56]});
        bm3[n] <= bn2[n] ? -$signed({1'b0, bpr[95:56]}) : $signed({1'b0, bpr[95:56]});
        am3[n] <= an2[n] ? -$signed({1'b0, apr[64:28]}) : $signed({1'b0, apr[64:28]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat.m00 <= sat32($signed({11'd0, Q30_ONE}) - 43'(dm3[0]));
      mat.m11 <= sat32($signed({11'd0, Q30_ONE}) - 43'(dm3[1]));
      mat.m22 <= sat32($signed({11'd0, Q30_ONE}) - 43'(dm3[2]));
      mat.m01 <= sat32(43'(bm3[0]) - 43'(am3[0]));
      mat.m10 <= sat32(43'(bm3[0]) + 43'(am3[0]));
      mat.m02 <= sat32(43'(bm3[1]) + 43'(am3[1]));
      mat.m20 <= sat32(43'(bm3[1]) - 43'(am3[1]));
      mat.m12 <= sat32(43'(bm3[2]) - 43'(am3[2]));
      mat.m21 <= sat32(43'(bm3[2]) + 43'(am3[2]));
    end
  end

endmodule

### rtl/so3_exponential_map_core_chk.sv
// ----------------------------------------------------------------------------
// so3_exponential_map_core_chk
// Port-level checks of the exponential map core, bound to the top level.
// ----------------------------------------------------------------------------
`include "so3_exponential_map_core_macros.svh"

module so3_exponential_map_core_chk import so3em_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rot_valid,
  input logic rot_ready,
  input logic mat_valid,
  input logic mat_ready,
  input mat_t mat
);

  // reset empties the pipeline
  `SO3_ASSERT_ALL(a_rst_empty, rst |=> !mat_valid, "result valid right after reset")

  // requests are refused only behind a result that is not taken
  `SO3_ASSERT_RUN(a_ready_map, rot_ready == (!mat_valid || mat_ready), "request ready mismatch")

  // a refused request leaves the pending result in place
  `SO3_ASSERT_RUN(a_stall_hold, rot_valid && !rot_ready |=> mat_valid && $stable(mat), "stalled result changed")

  `SO3_ASSERT_RUN(a_out_hold, mat_valid && !mat_ready |=> mat_valid && $stable(mat), "result dropped while stalled")

endmodule

bind so3_exponential_map_core so3_exponential_map_core_chk u_chk (.*);
